>>> design/prt_pkg.sv
package prt_pkg;

  localparam int unsigned PRT_NUM_SLOTS  = 16;
  localparam int unsigned PRT_COUNT_BITS = 16;
  localparam int unsigned PRT_MODE_BITS  = 8;

  localparam int unsigned SLOT_IDX_W   = 4;
  localparam int unsigned CNT_FIELD_W  = 16;
  localparam int unsigned MODE_FIELD_W = 8;
  localparam int unsigned STEP_W       = 8;
  localparam int unsigned CFG_IDX_W    = 2;
  localparam int unsigned CFG_DATA_W   = 8;

  typedef enum logic {
    CMD_TICK  = 1'b0,
    CMD_WRITE = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OP_MODE   = 2'd0,
    CFG_STEP_SIZE = 2'd1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_e;

endpackage

>>> design/prt_if.sv
interface prt_in_if import prt_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [SLOT_IDX_W-1:0]   slot_index;
  logic                    slot_enable;
  logic [CNT_FIELD_W-1:0]  period_ticks;
  logic [CNT_FIELD_W-1:0]  startup_delay;
  logic [MODE_FIELD_W-1:0] mode_mask;

  modport source (
    output valid, cmd, slot_index, slot_enable, period_ticks, startup_delay, mode_mask,
    input  ready
  );
  modport sink (
    input  valid, cmd, slot_index, slot_enable, period_ticks, startup_delay, mode_mask,
    output ready
  );
endinterface

interface prt_out_if import prt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [SLOT_IDX_W-1:0] released_slot;
  logic                  last_of_tick;

  modport source (output valid, released_slot, last_of_tick, input ready);
  modport sink (input valid, released_slot, last_of_tick, output ready);
endinterface

interface prt_cfg_if import prt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> design/prt_slot_mem.sv
module prt_slot_mem #(
  parameter int unsigned DEPTH  = 16,
  parameter int unsigned ADDR_W = 4,
  parameter int unsigned DATA_W = 40
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> design/prt_dec_unit.sv
module prt_dec_unit
  import prt_pkg::*;
#(
  parameter int unsigned CNT_W  = 16,
  parameter int unsigned MODE_W = 8
) (
  input  logic [CNT_W-1:0]  count_i,
  input  logic [CNT_W-1:0]  period_i,
  input  logic [STEP_W-1:0] step_i,
  input  logic [MODE_W-1:0] mask_i,
  input  logic [MODE_W-1:0] op_mode_i,
  output logic [CNT_W-1:0]  count_o,
  output logic              expire_o,
  output logic              match_o
);

  localparam int unsigned DIFF_W = ((CNT_W > STEP_W) ? CNT_W : STEP_W) + 1;

  logic [DIFF_W-1:0] diff;

  assign diff     = DIFF_W'(count_i) - DIFF_W'(step_i);
  assign expire_o = diff[DIFF_W-1] || (diff == '0);
  assign count_o  = expire_o ? period_i : diff[CNT_W-1:0];
  assign match_o  = |(mask_i & op_mode_i);

endmodule

>>> design/periodic_task_release_timer.sv
// channel | dir | payload                                              | transaction
// in_i    | in  | cmd slot_index slot_enable period_ticks startup_delay | valid & ready
//         |     | mode_mask                                            |
// out_o   | out | released_slot last_of_tick                           | valid & ready
// cfg_i   | in  | index data                                           | valid & ready
//
// Write: ready stays high. Tick: one slot per cycle, unless the output stalls,
// through the shared decrement/compare unit and the slot memory read port.
// One release is held back until the next one arrives (last_of_tick low) or the
// scan ends (last_of_tick high); a stalled output stops the scan at a releasing slot.
// Reset clears the FSM, slot enables and output valid; slot memory needs no clearing.
module periodic_task_release_timer
  import prt_pkg::*;
#(
  parameter int unsigned NUM_SLOTS  = PRT_NUM_SLOTS,
  parameter int unsigned COUNT_BITS = PRT_COUNT_BITS,
  parameter int unsigned MODE_BITS  = PRT_MODE_BITS
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  prt_in_if.sink   in_i,
  prt_out_if.source out_o,
  prt_cfg_if.sink  cfg_i
);

  localparam int unsigned IW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int unsigned CW    = (COUNT_BITS < CNT_FIELD_W) ? COUNT_BITS : CNT_FIELD_W;
  localparam int unsigned MW    = (MODE_BITS < MODE_FIELD_W) ? MODE_BITS : MODE_FIELD_W;
  localparam int unsigned MEM_W = 2 * CW + MW;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);

  state_e state_q, state_d;

  logic [MW-1:0]     op_mode_q;
  logic [STEP_W-1:0] step_q;

  logic [NUM_SLOTS-1:0] slot_en_q;
  logic [IW-1:0]        cur_q, cur_d;
  logic                 pend_v_q, pend_v_d;
  logic [IW-1:0]        pend_idx_q, pend_idx_d;
  logic                 out_v_q, out_v_d;
  logic [IW-1:0]        out_idx_q, out_idx_d;
  logic                 out_last_q, out_last_d;

  logic              mem_we;
  logic [IW-1:0]     mem_waddr, mem_raddr;
  logic [MEM_W-1:0]  mem_wdata, mem_rdata;

  logic [CW-1:0] rd_count, rd_period, new_count;
  logic [MW-1:0] rd_mask;
  logic          expire, match;

  logic tick_acc, wr_acc, wr_in_range;
  logic en, rel, out_free, stall, adv, push_mid, push_last;

  assign rd_count  = mem_rdata[CW-1:0];
  assign rd_period = mem_rdata[2*CW-1:CW];
  assign rd_mask   = mem_rdata[MEM_W-1:2*CW];

  prt_slot_mem #(
    .DEPTH  (NUM_SLOTS),
    .ADDR_W (IW),
    .DATA_W (MEM_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  prt_dec_unit #(
    .CNT_W  (CW),
    .MODE_W (MW)
  ) u_dec (
    .count_i   (rd_count),
    .period_i  (rd_period),
    .step_i    (step_q),
    .mask_i    (rd_mask),
    .op_mode_i (op_mode_q),
    .count_o   (new_count),
    .expire_o  (expire),
    .match_o   (match)
  );

  assign in_i.ready          = (state_q == ST_IDLE);
  assign cfg_i.ready         = 1'b1;
  assign out_o.valid         = out_v_q;
  assign out_o.released_slot = SLOT_IDX_W'(out_idx_q);
  assign out_o.last_of_tick  = out_last_q;

  assign tick_acc    = in_i.valid && in_i.ready && (in_i.cmd == CMD_TICK);
  assign wr_acc      = in_i.valid && in_i.ready && (in_i.cmd == CMD_WRITE);
  assign wr_in_range = int'(in_i.slot_index) < NUM_SLOTS;

  assign en        = slot_en_q[cur_q];
  assign rel       = (state_q == ST_SCAN) && en && expire && match;
  assign out_free  = !out_v_q || out_o.ready;
  assign stall     = rel && pend_v_q && !out_free;
  assign adv       = (state_q == ST_SCAN) && !stall;
  assign push_mid  = adv && rel && pend_v_q;
  assign push_last = (state_q == ST_FLUSH) && pend_v_q && out_free;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cur_q;
    mem_wdata = {rd_mask, rd_period, new_count};
    if (wr_acc && wr_in_range) begin
      mem_we    = 1'b1;
      mem_waddr = IW'(in_i.slot_index);
      mem_wdata = {in_i.mode_mask[MW-1:0], in_i.period_ticks[CW-1:0],
                   in_i.startup_delay[CW-1:0]};
    end else if (adv && en) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    if (state_q != ST_SCAN) begin
      mem_raddr = '0;
    end else if (!stall && (cur_q != LAST_IDX)) begin
      mem_raddr = cur_q + 1'b1;
    end else begin
      mem_raddr = cur_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    pend_v_d   = pend_v_q;
    pend_idx_d = pend_idx_q;
    out_v_d    = out_v_q;
    out_idx_d  = out_idx_q;
    out_last_d = out_last_q;

    if (out_o.ready) begin
      out_v_d = 1'b0;
    end
    if (push_mid || push_last) begin
      out_v_d    = 1'b1;
      out_idx_d  = pend_idx_q;
      out_last_d = push_last;
    end

    case (state_q)
      ST_IDLE: begin
        cur_d = '0;
        if (tick_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (adv) begin
          cur_d = cur_q + 1'b1;
          if (rel) begin
            pend_v_d   = 1'b1;
            pend_idx_d = cur_q;
          end
          if (cur_q == LAST_IDX) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (push_last) begin
          pend_v_d = 1'b0;
        end
        if (!pend_v_q || out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      cur_q      <= '0;
      pend_v_q   <= 1'b0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      pend_v_q   <= pend_v_d;
      out_v_q    <= out_v_d;
      out_last_q <= out_last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    out_idx_q  <= out_idx_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_en_q <= '0;
    end else if (wr_acc && wr_in_range) begin
      slot_en_q[IW'(in_i.slot_index)] <= in_i.slot_enable;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= MW'(1);
      step_q    <= STEP_W'(1);
    end else if (cfg_i.valid && cfg_i.ready) begin
      case (cfg_i.index)
        CFG_OP_MODE:   op_mode_q <= cfg_i.data[MW-1:0];
        CFG_STEP_SIZE: step_q    <= cfg_i.data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> design/prt_checker.sv
module prt_checker
  import prt_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  in_cmd_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [SLOT_IDX_W-1:0] out_slot_i,
  input logic                  out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_slot_i) && $stable(out_last_i))
    else $error("release result changed while stalled");

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && (in_cmd_i == CMD_TICK) |=> !in_ready_i)
    else $error("ready after tick transaction");

  a_rel_in_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("release result outside a tick");

  a_not_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("tick ended without a final release");

endmodule

bind periodic_task_release_timer prt_checker u_prt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_cmd_i    (in_i.cmd),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_slot_i  (out_o.released_slot),
  .out_last_i  (out_o.last_of_tick)
);
